@@ src/sfcc_pkg.sv @@
// Shared types, constants and functions for the sensor reply checker and converter.
`default_nettype none

package sfcc_pkg;

  localparam int unsigned REPLY_LEN = 6;
  localparam logic [7:0] CRC_INIT = 8'hFF;
  localparam logic [7:0] CRC_POLY = 8'h31;

  localparam int unsigned TEMP_SPAN   = 1750;
  localparam int unsigned TEMP_OFFSET = 450;
  localparam int unsigned HUM_SPAN    = 125;
  localparam int unsigned HUM_OFFSET  = 6;
  localparam int unsigned HUM_MAX     = 100;
  localparam int unsigned RAW_FULL    = 65535;
  localparam int unsigned ROUND_BIAS  = RAW_FULL / 2;

  // Widths of the scaled sums: TEMP_SPAN*RAW_FULL+ROUND_BIAS fits in 27 bits.
  localparam int unsigned SCALED_W = 27;
  localparam int unsigned QUOT_W   = SCALED_W - 16;

  typedef enum logic [1:0] {
    ERR_NONE     = 2'd0,
    ERR_TEMP_CRC = 2'd1,
    ERR_HUM_CRC  = 2'd2,
    ERR_BUS      = 2'd3
  } err_code_t;

  typedef struct packed {
    logic [7:0] rx_byte;
    logic       frame_start;
    logic       bus_error;
  } in_item_t;

  typedef struct packed {
    logic              reading_valid;
    logic signed [11:0] temperature_tenths;
    logic [6:0]        humidity_percent;
    logic [1:0]        error_code;
  } out_item_t;

  // One finished reply (or a bus error) handed from the front to the back.
  typedef struct packed {
    logic [1:0]  code;
    logic [15:0] raw_temp;
    logic [15:0] raw_hum;
  } job_t;

  function automatic logic [7:0] crc8_byte(input logic [7:0] crc, input logic [7:0] b);
    logic [7:0] c;
    c = crc ^ b;
    for (int i = 0; i < 8; i++) begin
      if (c[7]) begin
        c = {c[6:0], 1'b0} ^ CRC_POLY;
      end else begin
        c = {c[6:0], 1'b0};
      end
    end
    return c;
  endfunction

  // floor(y / 65535): the estimate y>>16 is low by at most one.
  function automatic logic [QUOT_W-1:0] div_full(input logic [SCALED_W-1:0] y);
    logic [QUOT_W-1:0] q0;
    logic [16:0]       rem;
    q0  = y[SCALED_W-1:16];
    rem = {1'b0, y[15:0]} + 17'(q0);
    return (rem >= 17'(RAW_FULL)) ? q0 + QUOT_W'(1) : q0;
  endfunction

endpackage

`default_nettype wire

@@ src/sensor_frame_crc_convert_top.sv @@
// A reply end or bus error gives a result through the queue, stage-1 and output registers.
// Throughput: one request per cycle while the queue has room; the front checks one byte per
// cycle, the back converts one reply per cycle, and a two-entry queue absorbs output stalls.
// Requests that do not end a reply produce no result.
// Reset (rst_n low, synchronous) clears the byte position, restarts the CRC at 0xFF
// and empties the queue and pipeline; no clearing pass is needed.
`default_nettype none

module sensor_frame_crc_convert_top (
  input  wire logic                clk,
  input  wire logic                rst_n,
  input  wire logic                in_valid,
  output logic                     in_ready,
  input  wire sfcc_pkg::in_item_t  in_data,
  output logic                     out_valid,
  input  wire logic                out_ready,
  output sfcc_pkg::out_item_t      out_data
);

  logic           push_valid, push_ready;
  sfcc_pkg::job_t push_job;
  logic           pop_valid, pop_ready;
  sfcc_pkg::job_t pop_job;

  sfcc_front u_front (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .in_data    (in_data),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job)
  );

  sfcc_queue u_queue (
    .clk        (clk),
    .rst_n      (rst_n),
    .push_valid (push_valid),
    .push_ready (push_ready),
    .push_job   (push_job),
    .pop_valid  (pop_valid),
    .pop_ready  (pop_ready),
    .pop_job    (pop_job)
  );

  sfcc_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .pop_valid (pop_valid),
    .pop_ready (pop_ready),
    .pop_job   (pop_job),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_data  (out_data)
  );

endmodule

`default_nettype wire

@@ src/sfcc_front.sv @@
// Front end: byte position tracking, CRC checking and reply assembly.
`default_nettype none

module sfcc_front (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              in_valid,
  output logic                   in_ready,
  input  wire sfcc_pkg::in_item_t in_data,
  output logic                   push_valid,
  input  wire logic              push_ready,
  output sfcc_pkg::job_t         push_job
);

  logic [2:0]  pos_r, pos_nxt;
  logic [7:0]  crc_r, crc_nxt;
  logic [15:0] raw_t_r, raw_t_nxt;
  logic [15:0] raw_h_r, raw_h_nxt;
  logic        tok_r, tok_nxt;

  logic [2:0] pos_eff;
  logic [7:0] crc_base;
  logic [7:0] crc_upd;
  logic       accept;

  assign in_ready = push_ready;
  assign accept   = in_valid && in_ready;

  always_comb begin
    pos_eff  = (in_data.frame_start || pos_r >= 3'(sfcc_pkg::REPLY_LEN)) ? 3'd0 : pos_r;
    crc_base = in_data.frame_start ? sfcc_pkg::CRC_INIT : crc_r;
    crc_upd  = sfcc_pkg::crc8_byte(crc_base, in_data.rx_byte);

    pos_nxt    = pos_r;
    crc_nxt    = crc_r;
    raw_t_nxt  = raw_t_r;
    raw_h_nxt  = raw_h_r;
    tok_nxt    = tok_r;
    push_valid = 1'b0;
    push_job.code     = sfcc_pkg::ERR_BUS;
    push_job.raw_temp = raw_t_r;
    push_job.raw_hum  = raw_h_r;

    if (accept) begin
      if (in_data.bus_error) begin
        pos_nxt    = 3'd0;
        crc_nxt    = sfcc_pkg::CRC_INIT;
        push_valid = 1'b1;
      end else begin
        case (pos_eff)
          3'd0: begin
            raw_t_nxt = {in_data.rx_byte, 8'h00};
            crc_nxt   = crc_upd;
            pos_nxt   = 3'd1;
          end
          3'd1: begin
            raw_t_nxt = {raw_t_r[15:8], in_data.rx_byte};
            crc_nxt   = crc_upd;
            pos_nxt   = 3'd2;
          end
          3'd2: begin
            tok_nxt = (crc_base == in_data.rx_byte);
            crc_nxt = sfcc_pkg::CRC_INIT;
            pos_nxt = 3'd3;
          end
          3'd3: begin
            raw_h_nxt = {in_data.rx_byte, 8'h00};
            crc_nxt   = crc_upd;
            pos_nxt   = 3'd4;
          end
          3'd4: begin
            raw_h_nxt = {raw_h_r[15:8], in_data.rx_byte};
            crc_nxt   = crc_upd;
            pos_nxt   = 3'd5;
          end
          default: begin
            // Last byte: the humidity checksum closes the reply.
            crc_nxt    = sfcc_pkg::CRC_INIT;
            pos_nxt    = 3'd0;
            push_valid = 1'b1;
            if (!tok_r) begin
              push_job.code = sfcc_pkg::ERR_TEMP_CRC;
            end else if (crc_base != in_data.rx_byte) begin
              push_job.code = sfcc_pkg::ERR_HUM_CRC;
            end else begin
              push_job.code = sfcc_pkg::ERR_NONE;
            end
          end
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      pos_r   <= 3'd0;
      crc_r   <= sfcc_pkg::CRC_INIT;
      raw_t_r <= 16'd0;
      raw_h_r <= 16'd0;
      tok_r   <= 1'b0;
    end else begin
      pos_r   <= pos_nxt;
      crc_r   <= crc_nxt;
      raw_t_r <= raw_t_nxt;
      raw_h_r <= raw_h_nxt;
      tok_r   <= tok_nxt;
    end
  end

endmodule

`default_nettype wire

@@ src/sfcc_queue.sv @@
// Two-entry queue of finished replies between the front and the back.
`default_nettype none

module sfcc_queue (
  input  wire logic            clk,
  input  wire logic            rst_n,
  input  wire logic            push_valid,
  output logic                 push_ready,
  input  wire sfcc_pkg::job_t  push_job,
  output logic                 pop_valid,
  input  wire logic            pop_ready,
  output sfcc_pkg::job_t       pop_job
);

  sfcc_pkg::job_t entry_r [2];
  logic       wr_ptr_r, wr_ptr_nxt;
  logic       rd_ptr_r, rd_ptr_nxt;
  logic [1:0] count_r, count_nxt;
  logic       do_push, do_pop;

  assign push_ready = (count_r != 2'd2);
  assign pop_valid  = (count_r != 2'd0);
  assign pop_job    = entry_r[rd_ptr_r];
  assign do_push    = push_valid && push_ready;
  assign do_pop     = pop_valid && pop_ready;

  always_comb begin
    wr_ptr_nxt = do_push ? !wr_ptr_r : wr_ptr_r;
    rd_ptr_nxt = do_pop ? !rd_ptr_r : rd_ptr_r;
    count_nxt  = count_r + 2'(do_push) - 2'(do_pop);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= 1'b0;
      rd_ptr_r <= 1'b0;
      count_r  <= 2'd0;
    end else begin
      wr_ptr_r <= wr_ptr_nxt;
      rd_ptr_r <= rd_ptr_nxt;
      count_r  <= count_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      entry_r[wr_ptr_r] <= push_job;
    end
  end

endmodule

`default_nettype wire

@@ src/sfcc_back.sv @@
// Back end: scales the raw words and forms the result in a two-stage pipeline.
`default_nettype none

module sfcc_back (
  input  wire logic           clk,
  input  wire logic           rst_n,
  input  wire logic           pop_valid,
  output logic                pop_ready,
  input  wire sfcc_pkg::job_t pop_job,
  output logic                out_valid,
  input  wire logic           out_ready,
  output sfcc_pkg::out_item_t out_data
);

  localparam int unsigned SW = sfcc_pkg::SCALED_W;
  localparam int unsigned QW = sfcc_pkg::QUOT_W;

  logic          s1_valid_r, s1_valid_nxt;
  logic [1:0]    s1_code_r;
  logic [SW-1:0] s1_t_r;
  logic [SW-1:0] s1_h_r;

  logic                out_valid_r, out_valid_nxt;
  sfcc_pkg::out_item_t out_data_r;
  sfcc_pkg::out_item_t result;

  logic          out_free;
  logic [QW-1:0] t_q;
  logic [QW-1:0] h_q;
  logic [6:0]    h_round;

  assign out_free  = !out_valid_r || out_ready;
  assign pop_ready = !s1_valid_r || out_free;
  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

  // Stage 1: constant multiply plus the half-divisor bias for rounding.
  always_ff @(posedge clk) begin
    if (pop_valid && pop_ready) begin
      s1_code_r <= pop_job.code;
      s1_t_r    <= SW'(pop_job.raw_temp) * SW'(sfcc_pkg::TEMP_SPAN) + SW'(sfcc_pkg::ROUND_BIAS);
      s1_h_r    <= SW'(pop_job.raw_hum) * SW'(sfcc_pkg::HUM_SPAN) + SW'(sfcc_pkg::ROUND_BIAS);
    end
  end

  // Stage 2: divide by full scale, offset, clamp the humidity; failed replies carry zeros.
  always_comb begin
    t_q     = sfcc_pkg::div_full(s1_t_r);
    h_q     = sfcc_pkg::div_full(s1_h_r);
    h_round = h_q[6:0];
    result.reading_valid      = 1'b0;
    result.temperature_tenths = 12'sd0;
    result.humidity_percent   = 7'd0;
    result.error_code         = s1_code_r;
    if (s1_code_r == sfcc_pkg::ERR_NONE) begin
      result.reading_valid      = 1'b1;
      result.temperature_tenths = $signed(12'(t_q) - 12'(sfcc_pkg::TEMP_OFFSET));
      if (h_round < 7'(sfcc_pkg::HUM_OFFSET)) begin
        result.humidity_percent = 7'd0;
      end else if (h_round - 7'(sfcc_pkg::HUM_OFFSET) > 7'(sfcc_pkg::HUM_MAX)) begin
        result.humidity_percent = 7'(sfcc_pkg::HUM_MAX);
      end else begin
        result.humidity_percent = h_round - 7'(sfcc_pkg::HUM_OFFSET);
      end
    end
  end

  always_comb begin
    s1_valid_nxt  = pop_ready ? pop_valid : s1_valid_r;
    out_valid_nxt = out_free ? s1_valid_r : out_valid_r;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
    end else begin
      s1_valid_r  <= s1_valid_nxt;
      out_valid_r <= out_valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_valid_r && out_free) begin
      out_data_r <= result;
    end
  end

endmodule

`default_nettype wire

@@ src/sfcc_checker.sv @@
// Port-level checks for the sensor reply converter, bound to the top level.
`default_nettype none

module sfcc_checker (
  input wire logic                clk,
  input wire logic                rst_n,
  input wire logic                out_valid,
  input wire logic                out_ready,
  input wire sfcc_pkg::out_item_t out_data
);

  a_reset_empty: assert property (@(posedge clk) !rst_n |=> !out_valid)
    else $error("result valid right after reset");

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_ready |=> out_valid && $stable(out_data))
    else $error("stalled result changed or dropped");

  a_good_fields: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_data.reading_valid |->
      out_data.error_code == sfcc_pkg::ERR_NONE && out_data.humidity_percent <= 7'd100)
    else $error("good reading with error code or humidity out of range");

  a_bad_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_data.reading_valid |->
      out_data.error_code != sfcc_pkg::ERR_NONE && out_data.temperature_tenths == 12'sd0
      && out_data.humidity_percent == 7'd0)
    else $error("failed reading carries values");

endmodule

bind sensor_frame_crc_convert_top sfcc_checker u_sfcc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .out_valid (out_valid),
  .out_ready (out_ready),
  .out_data  (out_data)
);

`default_nettype wire
